[rtl/qrs_pkg.sv]
// Package: shared constants, types and commands of the QRS peak heart-rate estimator.
`default_nettype none
package qrs_pkg;

  localparam int unsigned DefBeatWindow   = 8;
  localparam int unsigned DefSampleBits   = 24;
  localparam int unsigned DefLevelFracBits = 8;

  localparam int unsigned InBits    = 24;
  localparam int unsigned RateBits  = 16;
  localparam int unsigned CfgBits   = 16;
  localparam int unsigned PosBits   = 32;
  localparam int unsigned CountBits = 16;
  localparam int unsigned SumBits   = 40;

  localparam logic [CfgBits-1:0] InitLengthReset = 16'd1000;
  localparam logic [CfgBits-1:0] RateFactorReset = 16'd15000;

  // configuration register indexes
  localparam logic [0:0] RegInitLength = 1'b0;
  localparam logic [0:0] RegRateFactor = 1'b1;

  // divider operand selection
  typedef enum logic [1:0] {
    DivMeanInt,
    DivMeanFrac,
    DivRate
  } div_sel_e;

  // controller to datapath commands
  typedef struct packed {
    logic     capture;     // latch sample, evaluate peak conditions
    logic     do_learn;    // learning peak update
    logic     do_restart;  // clear state
    logic     div_start;   // start divider
    div_sel_e div_sel;
    logic     seed_int;    // store integer mean quotient
    logic     seed_fin;    // finish seeding levels
    logic     classify;    // threshold test, noise/run update
    logic     close_run;   // signal update, beat push
    logic     rate_sat;    // zero span: saturate rate
    logic     rate_load;   // take quotient as rate
    logic     shift_samp;  // advance sample history
  } qrs_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_peak;
    logic is_learn;
    logic count_zero;
    logic seeded;
    logic below_thr;
    logic run_pending;
    logic window_full;
    logic span_zero;
    logic div_done;
  } qrs_sts_t;

endpackage
`default_nettype wire

[rtl/qrs_stream_if.sv]
// Interfaces: valid/ready input sample channel and result channel.
`default_nettype none
interface qrs_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] integrated_sample;
  modport source (output valid, output integrated_sample, input ready);
  modport sink   (input valid, input integrated_sample, output ready);
endinterface

interface qrs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] heart_rate_bpm;
  logic        beat_found;
  logic        restarted;
  modport source (output valid, output heart_rate_bpm, output beat_found, output restarted,
                  input ready);
  modport sink   (input valid, input heart_rate_bpm, input beat_found, input restarted,
                  output ready);
endinterface
`default_nettype wire

[rtl/qrs_divider.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none
module qrs_divider
  import qrs_pkg::*;
#(
  parameter int unsigned Width = 48
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [Width-1:0] dividend_i,
  input  wire logic [Width-1:0] divisor_i,
  output logic                  done_o,
  output logic [Width-1:0]      quot_o,
  output logic [Width-1:0]      rem_o
);
  localparam int unsigned CntBits = $clog2(Width + 1);

  logic [Width-1:0]   quot_q, quot_d, rem_q, rem_d, dsr_q;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d;
  logic [Width:0]     trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quot_q[Width-1]} - {1'b0, dsr_q};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      cnt_d  = CntBits'(Width);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[Width]) begin
        rem_d = trial[Width-1:0];
        quot_d = {quot_q[Width-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[Width-2:0], quot_q[Width-1]};
        quot_d = {quot_q[Width-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (start_i) dsr_q <= divisor_i;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;
endmodule
`default_nettype wire

[rtl/qrs_datapath.sv]
// Datapath: sample history, learning statistics, levels, run tracking, beat window, rate.
`default_nettype none
module qrs_datapath
  import qrs_pkg::*;
#(
  parameter int unsigned BeatWindow    = DefBeatWindow,
  parameter int unsigned SampleBits    = DefSampleBits,
  parameter int unsigned LevelFracBits = DefLevelFracBits
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire qrs_cmd_t            cmd_i,
  output qrs_sts_t                 sts_o,
  input  wire logic [InBits-1:0]   sample_i,
  input  wire logic [CfgBits-1:0]  init_length_i,
  input  wire logic [CfgBits-1:0]  rate_factor_i,
  output logic [RateBits-1:0]      rate_o
);
  localparam int unsigned LevBits  = SampleBits + LevelFracBits;
  localparam int unsigned FillBits = $clog2(BeatWindow + 1);
  localparam int unsigned IdxBits  = $clog2(BeatWindow);
  localparam int unsigned DivBits  = SumBits + LevelFracBits;
  localparam int unsigned WinM1    = BeatWindow - 1;

  logic [SampleBits-1:0] x_q, prev_q, older_q, lmax_q, best_q;
  logic [PosBits-1:0]    pos_q, best_pos_q;
  logic                  learn_over_q, seeded_q, run_q;
  logic [SumBits-1:0]    lsum_q;
  logic [CountBits-1:0]  lcnt_q;
  logic [LevBits-1:0]    noise_q, signal_q;
  logic [PosBits-1:0]    beats_q [BeatWindow];
  logic [FillBits-1:0]   fill_q;
  logic [RateBits-1:0]   rate_q;
  logic [DivBits-1:0]    qint_q;
  logic                  below_q;

  logic [PosBits-1:0]    peak_pos;
  logic [DivBits-1:0]    div_a, div_b, div_q, div_r;
  logic                  div_done;
  logic [LevBits+2:0]    scaled4, thr;
  logic [LevBits+2:0]    mean7;
  logic [LevBits+2:0]    sig_sm, noise_sm;
  logic [LevBits-1:0]    mean;
  logic [PosBits-1:0]    span;

  assign peak_pos = pos_q - 1'b1;

  // divider operand selection
  always_comb begin
    div_a = '0;
    div_b = DivBits'(lcnt_q);
    case (cmd_i.div_sel)
      DivMeanInt:  div_a = DivBits'(lsum_q);
      DivMeanFrac: div_a = DivBits'(div_r) << LevelFracBits;
      DivRate: begin
        div_a = DivBits'(rate_factor_i) * DivBits'(WinM1);
        div_b = DivBits'(span);
      end
      default: div_a = '0;
    endcase
  end

  qrs_divider #(.Width(DivBits)) u_div (
    .clk_i, .rst_ni,
    .start_i   (cmd_i.div_start),
    .dividend_i(div_a),
    .divisor_i (div_b),
    .done_o    (div_done),
    .quot_o    (div_q),
    .rem_o     (div_r)
  );

  // level arithmetic
  assign span     = beats_q[BeatWindow-1] - beats_q[0];
  assign scaled4  = (LevBits+3)'(prev_q) << (LevelFracBits + 2);
  assign thr      = (LevBits+3)'(noise_q) * 3 + (LevBits+3)'(signal_q);
  assign mean     = LevBits'(qint_q << LevelFracBits) + LevBits'(div_q);
  assign mean7    = (LevBits+3)'(mean) * 7;
  assign sig_sm   = (LevBits+3)'(signal_q) * 7 + ((LevBits+3)'(best_q) << LevelFracBits);
  assign noise_sm = (LevBits+3)'(noise_q) * 7 + ((LevBits+3)'(prev_q) << LevelFracBits);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0; prev_q <= '0; older_q <= '0; pos_q <= '0;
      learn_over_q <= 1'b0; seeded_q <= 1'b0; lmax_q <= '0; lsum_q <= '0; lcnt_q <= '0;
      noise_q <= '0; signal_q <= '0; run_q <= 1'b0; best_q <= '0; best_pos_q <= '0;
      fill_q <= '0; rate_q <= '0; below_q <= 1'b0;
    end else begin
      if (cmd_i.capture) x_q <= SampleBits'(sample_i);
      if (cmd_i.do_learn) begin
        if (prev_q > lmax_q) lmax_q <= prev_q;
        if (lcnt_q != '1) begin
          lsum_q <= lsum_q + SumBits'(prev_q);
          lcnt_q <= lcnt_q + 1'b1;
        end
      end
      if (cmd_i.do_restart) begin
        prev_q <= '0; older_q <= '0; pos_q <= '0;
        learn_over_q <= 1'b0; seeded_q <= 1'b0; lmax_q <= '0; lsum_q <= '0; lcnt_q <= '0;
        noise_q <= '0; signal_q <= '0; run_q <= 1'b0; best_q <= '0; best_pos_q <= '0;
        fill_q <= '0; rate_q <= '0;
      end
      if (cmd_i.seed_int) qint_q <= div_q;
      if (cmd_i.seed_fin) begin
        noise_q      <= LevBits'(mean7 >> 3);
        signal_q     <= LevBits'(((LevBits+3)'(lmax_q) << LevelFracBits) * 7 >> 3);
        seeded_q     <= 1'b1;
        learn_over_q <= 1'b1;
      end
      if (cmd_i.classify) begin
        below_q <= scaled4 < thr;
        if (scaled4 < thr) begin
          noise_q <= LevBits'(noise_sm >> 3);
        end else begin
          if (!run_q || prev_q > best_q) begin
            best_q     <= prev_q;
            best_pos_q <= peak_pos;
          end
          run_q <= 1'b1;
        end
      end
      if (cmd_i.close_run) begin
        signal_q   <= LevBits'(sig_sm >> 3);
        run_q      <= 1'b0;
        best_q     <= '0;
        best_pos_q <= '0;
        if (fill_q < FillBits'(BeatWindow)) fill_q <= fill_q + 1'b1;
      end
      if (cmd_i.rate_sat)  rate_q <= '1;
      if (cmd_i.rate_load) rate_q <= (div_q > DivBits'(16'hFFFF)) ? '1 : RateBits'(div_q);
      if (cmd_i.shift_samp) begin
        older_q <= prev_q;
        prev_q  <= x_q;
        pos_q   <= pos_q + 1'b1;
      end
    end
  end

  // beat window: fills in order, then slides
  always_ff @(posedge clk_i) begin
    if (cmd_i.close_run) begin
      if (fill_q < FillBits'(BeatWindow)) begin
        beats_q[IdxBits'(fill_q)] <= best_pos_q;
      end else begin
        for (int i = 0; i < BeatWindow - 1; i++) beats_q[i] <= beats_q[i+1];
        beats_q[BeatWindow-1] <= best_pos_q;
      end
    end
  end

  always_comb begin
    sts_o.is_peak     = (older_q < prev_q) && (x_q < prev_q);
    sts_o.is_learn    = !learn_over_q && (peak_pos < PosBits'(init_length_i));
    sts_o.count_zero  = (lcnt_q == '0);
    sts_o.seeded      = seeded_q;
    sts_o.below_thr   = below_q;
    sts_o.run_pending = run_q;
    sts_o.window_full = (fill_q == FillBits'(BeatWindow));
    sts_o.span_zero   = (span == '0);
    sts_o.div_done    = div_done;
  end

  assign rate_o = rate_q;
endmodule
`default_nettype wire

[rtl/qrs_ctrl.sv]
// Controller: sequences one sample through peak handling, division and output.
`default_nettype none
module qrs_ctrl
  import qrs_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output logic          beat_o,
  output logic          restart_o,
  output qrs_cmd_t      cmd_o,
  input  wire qrs_sts_t sts_i
);
  typedef enum logic [3:0] {
    StIdle, StEval, StMeanInt, StMeanFrac, StSeed, StClass, StAfter,
    StClose, StRate, StShift, StOut
  } state_e;

  state_e state_q, state_d;
  logic   beat_q, beat_d, rst_q, rst_d;

  always_comb begin
    state_d = state_q;
    beat_d  = beat_q;
    rst_d   = rst_q;
    cmd_o   = '0;
    cmd_o.div_sel = DivMeanInt;
    case (state_q)
      StIdle: if (in_valid_i) begin
        cmd_o.capture = 1'b1;
        beat_d = 1'b0;
        rst_d  = 1'b0;
        state_d = StEval;
      end
      StEval: begin
        if (!sts_i.is_peak) state_d = StShift;
        else if (sts_i.is_learn) begin
          cmd_o.do_learn = 1'b1;
          state_d = StShift;
        end else if (sts_i.count_zero) begin
          cmd_o.do_restart = 1'b1;
          rst_d = 1'b1;
          state_d = StShift;
        end else if (!sts_i.seeded) begin
          cmd_o.div_start = 1'b1;
          state_d = StMeanInt;
        end else state_d = StClass;
      end
      StMeanInt: if (sts_i.div_done) begin
        cmd_o.seed_int  = 1'b1;
        cmd_o.div_sel   = DivMeanFrac;
        cmd_o.div_start = 1'b1;
        state_d = StMeanFrac;
      end
      StMeanFrac: if (sts_i.div_done) state_d = StSeed;
      StSeed: begin
        cmd_o.seed_fin = 1'b1;
        state_d = StClass;
      end
      StClass: begin
        cmd_o.classify = 1'b1;
        // run closes only when the peak is below threshold and a run was open
        state_d = StAfter;
      end
      StAfter: begin
        if (sts_i.below_thr && sts_i.run_pending) begin
          cmd_o.close_run = 1'b1;
          beat_d = 1'b1;
          state_d = StClose;
        end else state_d = StShift;
      end
      StClose: begin
        if (!sts_i.window_full) state_d = StShift;
        else if (sts_i.span_zero) begin
          cmd_o.rate_sat = 1'b1;
          state_d = StShift;
        end else begin
          cmd_o.div_sel   = DivRate;
          cmd_o.div_start = 1'b1;
          state_d = StRate;
        end
      end
      StRate: if (sts_i.div_done) begin
        cmd_o.rate_load = 1'b1;
        state_d = StShift;
      end
      StShift: begin
        cmd_o.shift_samp = 1'b1;
        state_d = StOut;
      end
      StOut: if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // classify updates noise or the run; close_run follows in StAfter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      beat_q  <= 1'b0;
      rst_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      beat_q  <= beat_d;
      rst_q   <= rst_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign beat_o      = beat_q;
  assign restart_o   = rst_q;
endmodule
`default_nettype wire

[rtl/qrs_peak_heart_rate_estimator.sv]
// QRS peak heart-rate estimator top level: config registers, controller, datapath.
// Seeding the levels runs two 48-bit divisions (integer and fractional mean); a beat adds a
//   close step, and with a full window and a nonzero span a rate division follows.
// Throughput: one sample at a time; next sample accepted after the result beat is taken.
// Reset (rst_ni, async, active low) clears the control and level state; configuration returns to
//   init_length 1000 and rate_factor 15000. The beat window and divider data need no clearing.
`default_nettype none
module qrs_peak_heart_rate_estimator
  import qrs_pkg::*;
#(
  parameter int unsigned BEAT_WINDOW     = DefBeatWindow,
  parameter int unsigned SAMPLE_BITS     = DefSampleBits,
  parameter int unsigned LEVEL_FRAC_BITS = DefLevelFracBits
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  qrs_in_if.sink                  in_if,
  qrs_out_if.source               out_if,
  input  wire logic               cfg_we_i,
  input  wire logic [0:0]         cfg_idx_i,
  input  wire logic [CfgBits-1:0] cfg_data_i
);
  logic [CfgBits-1:0] init_length_q, rate_factor_q;
  qrs_cmd_t           cmd;
  qrs_sts_t           sts;
  logic [RateBits-1:0] rate;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_length_q <= InitLengthReset;
      rate_factor_q <= RateFactorReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegInitLength: init_length_q <= cfg_data_i;
        RegRateFactor: rate_factor_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  qrs_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .beat_o     (out_if.beat_found),
    .restart_o  (out_if.restarted),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  qrs_datapath #(
    .BeatWindow   (BEAT_WINDOW),
    .SampleBits   (SAMPLE_BITS),
    .LevelFracBits(LEVEL_FRAC_BITS)
  ) u_dp (
    .clk_i, .rst_ni,
    .cmd_i        (cmd),
    .sts_o        (sts),
    .sample_i     (in_if.integrated_sample),
    .init_length_i(init_length_q),
    .rate_factor_i(rate_factor_q),
    .rate_o       (rate)
  );

  assign out_if.heart_rate_bpm = rate;
endmodule
`default_nettype wire
